FILE: rtl/core/ssp_pkg.sv
package ssp_pkg;

  // Header byte that opens every status packet (sent twice).
  localparam logic [7:0] HDR_BYTE = 8'hFF;

  // Smallest legal length field: error byte plus checksum.
  localparam logic [7:0] MIN_LENGTH = 8'd2;

  // Width of the packed result data word (35 used bits, padded to bytes).
  localparam int unsigned OUT_DATA_W = 40;

  // Role of a byte within the packet.
  typedef enum logic [2:0] {
    ROLE_DISCARD  = 3'd0,
    ROLE_HEADER1  = 3'd1,
    ROLE_HEADER2  = 3'd2,
    ROLE_ID       = 3'd3,
    ROLE_LENGTH   = 3'd4,
    ROLE_ERROR    = 3'd5,
    ROLE_DATA     = 3'd6,
    ROLE_CHECKSUM = 3'd7
  } role_t;

  // One result item, as produced by the parser for one received byte.
  typedef struct packed {
    logic [7:0] byte_value;
    role_t      byte_role;
    logic [7:0] data_index;
    logic [7:0] packet_id;
    logic [7:0] servo_error;
    logic       packet_good;
    logic       packet_bad;
    logic       id_match;
  } result_t;

endpackage

FILE: rtl/core/ssp_in_stage.sv
module ssp_in_stage (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,     // [7:0] rx_byte
  input  logic       adv_ready,    // downstream stage can take the held item
  output logic       hold_valid,
  output logic [7:0] hold_byte
);

  logic       valid_r;
  logic       valid_nxt;
  logic [7:0] byte_r;
  logic       take;
  logic       leave;

  // The held item leaves when the result stage has room; a new one may enter in the same cycle.
  assign leave     = valid_r && adv_ready;
  assign in_tready = !valid_r || adv_ready;
  assign take      = in_tvalid && in_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (leave) begin
      valid_nxt = 1'b0;
    end
  end

  // Valid flag is control state; the byte register needs no reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      byte_r <= in_tdata;
    end
  end

  assign hold_valid = valid_r;
  assign hold_byte  = byte_r;

endmodule

FILE: rtl/core/ssp_parser.sv
module ssp_parser (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [7:0]       cfg_wr_data,
  input  logic             step,       // the held byte moves to the result stage
  input  logic [7:0]       rx_byte,
  output ssp_pkg::result_t result
);

  import ssp_pkg::*;

  typedef enum logic [2:0] {
    PH_HDR1 = 3'd0,
    PH_HDR2 = 3'd1,
    PH_ID   = 3'd2,
    PH_LEN  = 3'd3,
    PH_ERR  = 3'd4,
    PH_DATA = 3'd5,
    PH_CHK  = 3'd6
  } phase_t;

  phase_t     phase_r, phase_nxt;
  logic [7:0] expected_id_r;
  logic [7:0] held_id_r, held_id_nxt;
  logic [7:0] held_length_r, held_length_nxt;
  logic [7:0] held_error_r, held_error_nxt;
  logic [7:0] data_seen_r, data_seen_nxt;
  logic [7:0] sum_r, sum_nxt;
  logic [7:0] sum_plus;
  logic [7:0] seen_plus;
  result_t    res;

  assign sum_plus  = sum_r + rx_byte;
  assign seen_plus = data_seen_r + 8'd1;

  // Classify the byte and work out the next parse state.
  always_comb begin
    phase_nxt       = phase_r;
    held_id_nxt     = held_id_r;
    held_length_nxt = held_length_r;
    held_error_nxt  = held_error_r;
    data_seen_nxt   = data_seen_r;
    sum_nxt         = sum_r;
    res             = '0;
    res.byte_value  = rx_byte;
    res.byte_role   = ROLE_DISCARD;

    case (phase_r)
      PH_HDR2: begin
        // A wrong second header byte is dropped and the hunt restarts.
        if (rx_byte == HDR_BYTE) begin
          res.byte_role = ROLE_HEADER2;
          phase_nxt     = PH_ID;
        end else begin
          phase_nxt = PH_HDR1;
        end
      end
      PH_ID: begin
        res.byte_role = ROLE_ID;
        res.packet_id = rx_byte;
        held_id_nxt   = rx_byte;
        sum_nxt       = rx_byte;
        phase_nxt     = PH_LEN;
      end
      PH_LEN: begin
        res.byte_role   = ROLE_LENGTH;
        res.packet_id   = held_id_r;
        held_length_nxt = rx_byte;
        data_seen_nxt   = '0;
        sum_nxt         = sum_plus;
        phase_nxt       = (rx_byte >= MIN_LENGTH) ? PH_ERR : PH_HDR1;
      end
      PH_ERR: begin
        res.byte_role   = ROLE_ERROR;
        res.packet_id   = held_id_r;
        res.servo_error = rx_byte;
        held_error_nxt  = rx_byte;
        sum_nxt         = sum_plus;
        phase_nxt       = (held_length_r > MIN_LENGTH) ? PH_DATA : PH_CHK;
      end
      PH_DATA: begin
        res.byte_role   = ROLE_DATA;
        res.data_index  = data_seen_r;
        res.packet_id   = held_id_r;
        res.servo_error = held_error_r;
        sum_nxt         = sum_plus;
        data_seen_nxt   = seen_plus;
        // Length is at least three here, so the subtraction cannot wrap.
        if (seen_plus >= (held_length_r - MIN_LENGTH)) begin
          phase_nxt = PH_CHK;
        end
      end
      PH_CHK: begin
        res.byte_role   = ROLE_CHECKSUM;
        res.packet_id   = held_id_r;
        res.servo_error = held_error_r;
        if (~sum_r == rx_byte) begin
          res.packet_good = 1'b1;
          res.id_match    = (held_id_r == expected_id_r);
        end else begin
          res.packet_bad = 1'b1;
        end
        phase_nxt = PH_HDR1;
      end
      default: begin
        // Waiting for the first header; unused codes behave the same.
        if (rx_byte == HDR_BYTE) begin
          res.byte_role = ROLE_HEADER1;
          phase_nxt     = PH_HDR2;
        end else begin
          phase_nxt = PH_HDR1;
        end
      end
    endcase
  end

  assign result = res;

  // Parse state advances once per item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_HDR1;
      held_id_r     <= '0;
      held_length_r <= '0;
      held_error_r  <= '0;
      data_seen_r   <= '0;
      sum_r         <= '0;
    end else if (step) begin
      phase_r       <= phase_nxt;
      held_id_r     <= held_id_nxt;
      held_length_r <= held_length_nxt;
      held_error_r  <= held_error_nxt;
      data_seen_r   <= data_seen_nxt;
      sum_r         <= sum_nxt;
    end
  end

  // Expected servo id register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expected_id_r <= 8'd1;
    end else if (cfg_wr_en) begin
      expected_id_r <= cfg_wr_data;
    end
  end

endmodule

FILE: rtl/core/ssp_out_stage.sv
module ssp_out_stage (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             load,
  input  ssp_pkg::result_t                 result,
  output logic                             load_ready,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [7:0] byte_value, [15:8] data_index, [23:16] packet_id, [31:24] servo_error,
  // [32] packet_good, [33] packet_bad, [34] id_match, [39:35] zero
  output logic [ssp_pkg::OUT_DATA_W-1:0]   out_tdata,
  output logic [2:0]                       out_tuser  // [2:0] byte_role
);

  import ssp_pkg::*;

  logic    valid_r;
  logic    valid_nxt;
  result_t res_r;

  // The register can take a new item when empty or when its item is taken now.
  assign load_ready = !valid_r || out_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= result;
    end
  end

  // Pack the result fields onto the stream ports.
  assign out_tvalid = valid_r;
  assign out_tuser  = res_r.byte_role;
  assign out_tdata  = {5'b0, res_r.id_match, res_r.packet_bad, res_r.packet_good,
                       res_r.servo_error, res_r.packet_id, res_r.data_index,
                       res_r.byte_value};

endmodule

FILE: rtl/core/servo_status_packet_parser.sv
// Path: an accepted item is held in the input register, then moves to the result
// register when the result stage has room; a stall keeps it in the input register.
// Throughput: one item per cycle unless out_tready stalls it; one parse step per byte.
// Reset (rst_n low, synchronous): both stages empty, parser hunts for the first
// header with all held fields and the running sum cleared, expected id set to 1.
module servo_status_packet_parser (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [7:0]                     in_tdata,    // [7:0] rx_byte
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // [7:0] byte_value, [15:8] data_index, [23:16] packet_id, [31:24] servo_error,
  // [32] packet_good, [33] packet_bad, [34] id_match, [39:35] zero
  output logic [ssp_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic [2:0]                     out_tuser,   // [2:0] byte_role
  input  logic                           cfg_wr_en,
  input  logic [7:0]                     cfg_wr_data
);

  import ssp_pkg::*;

  logic       hold_valid;
  logic [7:0] hold_byte;
  logic       load_ready;
  logic       step;
  result_t    result;

  // An item moves forward when the input stage holds one and the result stage has room.
  assign step = hold_valid && load_ready;

  ssp_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .adv_ready  (load_ready),
    .hold_valid (hold_valid),
    .hold_byte  (hold_byte)
  );

  ssp_parser u_parse (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .step        (step),
    .rx_byte     (hold_byte),
    .result      (result)
  );

  ssp_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (step),
    .result     (result),
    .load_ready (load_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

FILE: rtl/core/ssp_checker.sv
module ssp_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [ssp_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic [2:0]                     out_tuser
);

  import ssp_pkg::*;

  logic good;
  logic bad;
  logic match;
  logic is_chk;

  assign good   = out_tdata[32];
  assign bad    = out_tdata[33];
  assign match  = out_tdata[34];
  assign is_chk = (out_tuser == ROLE_CHECKSUM);

  // A stalled result item holds its payload.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result item changed while stalled");

  // The checksum byte carries exactly one verdict.
  a_one_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && is_chk |-> good != bad)
    else $error("checksum item without a single verdict");

  // Other roles carry no verdict flags.
  a_no_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !is_chk |-> !good && !bad && !match)
    else $error("verdict flag on a non-checksum item");

  // An id match is only reported on a good packet.
  a_match_good: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && match |-> good)
    else $error("id match without a good checksum");

  // Reset empties the result stage.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

endmodule

bind servo_status_packet_parser ssp_checker u_ssp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
